/* sv/gcr_pkg.sv */
// ----------------------------------------------------------------------------
// gcr_pkg: shared types, constants and glyph ROM
// Display limits, the printable code range, the queued cell descriptor and the
// 5x7 font table used by the character cell rasterizer.
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int DISPLAY_WIDTH  = 240;
  localparam int DISPLAY_HEIGHT = 320;

  localparam logic [7:0] FIRST_CODE    = 8'h20;
  localparam logic [7:0] LAST_CODE     = 8'h7E;
  localparam logic [7:0] FALLBACK_CODE = 8'h3F;

  localparam logic [2:0] GLYPH_COLS = 3'd5;
  localparam logic [2:0] GLYPH_ROWS = 3'd7;
  localparam logic [2:0] LAST_COL   = 3'd5;
  localparam logic [2:0] LAST_ROW   = 3'd7;

  // Two-entry queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Glyph columns in natural order; bit n of a column is row n.
  typedef logic [0:4][7:0] glyph_t;

  typedef struct packed {
    glyph_t      glyph;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] fg;
    logic [15:0] bg;
  } cell_t;

  function automatic logic [15:0] swap_bytes(input logic [15:0] c);
    return {c[7:0], c[15:8]};
  endfunction

  function automatic glyph_t glyph_rom(input logic [6:0] idx);
    glyph_t g;
    case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00005F0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147F147F14;
      7'd4:  g = 40'h242A7F2A12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001C224100;
      7'd9:  g = 40'h0041221C00;
      7'd10: g = 40'h082A1C2A08;
      7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3E5149453E;
      7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454B31;
      7'd20: g = 40'h1814127F10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3C4A494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291E;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0008142241;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h4122140800;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413E;
      7'd33: g = 40'h7E1111117E;
      7'd34: g = 40'h7F49494936;
      7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C;
      7'd37: g = 40'h7F49494941;
      7'd38: g = 40'h7F09090901;
      7'd39: g = 40'h3E4149497A;
      7'd40: g = 40'h7F0808087F;
      7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01;
      7'd43: g = 40'h7F08142241;
      7'd44: g = 40'h7F40404040;
      7'd45: g = 40'h7F020C027F;
      7'd46: g = 40'h7F0408107F;
      7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906;
      7'd49: g = 40'h3E4151215E;
      7'd50: g = 40'h7F09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017F0101;
      7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F;
      7'd55: g = 40'h3F4038403F;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007F414100;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h0041417F00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487F;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087E090102;
      7'd71: g = 40'h0C5252523E;
      7'd72: g = 40'h7F08040478;
      7'd73: g = 40'h00447D4000;
      7'd74: g = 40'h2040443D00;
      7'd75: g = 40'h7F10284400;
      7'd76: g = 40'h00417F4000;
      7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7C14141408;
      7'd81: g = 40'h081414187C;
      7'd82: g = 40'h7C08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020;
      7'd85: g = 40'h3C4040207C;
      7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h1008081008;
      default: g = 40'h0201510906;
    endcase
    return g;
  endfunction

endpackage

/* sv/gcr_front.sv */
// ----------------------------------------------------------------------------
// gcr_front: input classification
// Drops cells whose origin is off screen, maps non-printable codes to the
// question mark, looks up the glyph and byte-swaps both colours.
// ----------------------------------------------------------------------------
module gcr_front (
  input  logic              in_valid,
  input  logic [7:0]        in_char_code,
  input  logic [9:0]        in_cell_x,
  input  logic [9:0]        in_cell_y,
  input  logic [15:0]       in_fore_colour,
  input  logic [15:0]       in_back_colour,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output gcr_pkg::cell_t    push_cell
);

  logic       on_screen;
  logic [7:0] code_m;
  logic [6:0] rom_idx;

  assign on_screen = ({1'b0, in_cell_x} < 11'(gcr_pkg::DISPLAY_WIDTH)) &&
                     ({1'b0, in_cell_y} < 11'(gcr_pkg::DISPLAY_HEIGHT));

  always_comb begin
    if (in_char_code < gcr_pkg::FIRST_CODE || in_char_code > gcr_pkg::LAST_CODE) begin
      code_m = gcr_pkg::FALLBACK_CODE;
    end else begin
      code_m = in_char_code;
    end
  end

  assign rom_idx = 7'(code_m - gcr_pkg::FIRST_CODE);

  assign in_stall = q_full;
  // An accepted cell that starts off screen is simply not queued.
  assign push     = in_valid && !q_full && on_screen;

  assign push_cell.glyph = gcr_pkg::glyph_rom(rom_idx);
  assign push_cell.x     = in_cell_x;
  assign push_cell.y     = in_cell_y;
  assign push_cell.fg    = gcr_pkg::swap_bytes(in_fore_colour);
  assign push_cell.bg    = gcr_pkg::swap_bytes(in_back_colour);

endmodule

/* sv/gcr_queue.sv */
// ----------------------------------------------------------------------------
// gcr_queue: cell descriptor queue
// Short FIFO that decouples the classifier from the pixel sequencer.
// ----------------------------------------------------------------------------
module gcr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gcr_pkg::cell_t push_cell,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output gcr_pkg::cell_t head
);

  gcr_pkg::cell_t                      mem_r [gcr_pkg::QUEUE_DEPTH];
  logic [gcr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [gcr_pkg::QUEUE_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [gcr_pkg::QUEUE_CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == gcr_pkg::QUEUE_CNT_W'(gcr_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cell;
    end
  end

endmodule

/* sv/gcr_back.sv */
// ----------------------------------------------------------------------------
// gcr_back: pixel sequencer
// Walks the 6x8 cell in row-major order and drives one registered pixel word
// per cycle while the receiver does not stall, marking the last pixel of the cell.
// ----------------------------------------------------------------------------
module gcr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  gcr_pkg::cell_t head,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [15:0]    out_pixel_word,
  output logic [10:0]    out_pixel_x,
  output logic [10:0]    out_pixel_y,
  output logic           out_last_pixel
);

  gcr_pkg::cell_t cur_r, cur_nxt;
  logic           active_r, active_nxt;
  logic [2:0]     col_r, col_nxt;
  logic [2:0]     row_r, row_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    word_r;
  logic [10:0]    px_r;
  logic [10:0]    py_r;
  logic           last_r;

  logic           adv;
  logic           at_end;
  logic [7:0]     col_bits;
  logic           on;

  assign adv    = active_r && (!out_valid_r || !out_stall);
  assign at_end = (col_r == gcr_pkg::LAST_COL) && (row_r == gcr_pkg::LAST_ROW);
  // The next cell is taken in the cycle the last pixel moves out, so cells
  // follow each other without a gap.
  assign pop    = !q_empty && (!active_r || (adv && at_end));

  assign col_bits = (col_r < gcr_pkg::GLYPH_COLS) ? cur_r.glyph[col_r] : 8'h00;
  assign on       = (row_r < gcr_pkg::GLYPH_ROWS) && col_bits[row_r];

  always_comb begin
    cur_nxt       = cur_r;
    active_nxt    = active_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      if (col_r == gcr_pkg::LAST_COL) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
      if (at_end) begin
        active_nxt = 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      cur_nxt    = head;
      active_nxt = 1'b1;
      col_nxt    = '0;
      row_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv) begin
      word_r <= on ? cur_r.fg : cur_r.bg;
      px_r   <= {1'b0, cur_r.x} + {8'b0, col_r};
      py_r   <= {1'b0, cur_r.y} + {8'b0, row_r};
      last_r <= at_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = word_r;
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_last_pixel = last_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= gcr_pkg::LAST_COL)
    else $error("column counter out of range");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (active_r && col_r == '0 && row_r == '0))
    else $error("taken cell did not start at its first pixel");

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && at_end) |=> (out_valid_r && last_r))
    else $error("last pixel of a cell not marked");

endmodule

/* sv/glyph_cell_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// glyph_cell_rasterizer_top: 5x7 font character cell rasterizer
// Turns one character word into the 48 pixel words of its 6x8 cell.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries a character code, the
//   cell origin and the foreground and background RGB565 colours. The output
//   channel (out_valid / out_stall) carries one pixel word per handshake in
//   row-major order, with out_last_pixel set on the 48th word of the cell.
//   A cell whose origin lies at or past the display width or height yields
//   no words at all. Colours leave with their two bytes swapped.
//   The first pixel word of a cell passes through the queue, the cell register
//   of the sequencer and the output register before it appears.
//   The pixel sequencer emits one word per cycle while the receiver does not
//   stall, and consecutive cells follow without a gap. A two-entry queue
//   between classifier and sequencer lets the input keep accepting while the
//   sequencer works; in_stall rises only when that queue is full.
//   When the receiver stalls, the output word holds and the sequencer waits.
//   Reset (rst_n low, synchronous) empties the queue and the output stage.
// ----------------------------------------------------------------------------
module glyph_cell_rasterizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic [9:0]  in_cell_x,
  input  logic [9:0]  in_cell_y,
  input  logic [15:0] in_fore_colour,
  input  logic [15:0] in_back_colour,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_word,
  output logic [10:0] out_pixel_x,
  output logic [10:0] out_pixel_y,
  output logic        out_last_pixel
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  gcr_pkg::cell_t push_cell;
  gcr_pkg::cell_t head;

  gcr_front u_front (
    .in_valid       (in_valid),
    .in_char_code   (in_char_code),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_fore_colour (in_fore_colour),
    .in_back_colour (in_back_colour),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push),
    .push_cell      (push_cell)
  );

  gcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cell (push_cell),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  gcr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pixel_word (out_pixel_word),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

endmodule

/* sim/glyph_cell_rasterizer_top_tb.sv */
// ----------------------------------------------------------------------------
// glyph_cell_rasterizer_top_tb: self-checking bench for the cell rasterizer
// Feeds character words with directed edge cases and random content, renders
// each cell with an independent 5x7 font model and compares every pixel word
// against the block's output under three patterns of sender and receiver gaps.
// ----------------------------------------------------------------------------
module glyph_cell_rasterizer_top_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int CELL_PIXELS = 48;

  typedef struct {
    logic [7:0]  code;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] fg;
    logic [15:0] bg;
  } char_word_t;

  typedef struct {
    logic [15:0] colour;
    logic [10:0] x;
    logic [10:0] y;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = '0;
  logic [9:0]  in_cell_x = '0;
  logic [9:0]  in_cell_y = '0;
  logic [15:0] in_fore_colour = '0;
  logic [15:0] in_back_colour = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pixel_word;
  logic [10:0] out_pixel_x;
  logic [10:0] out_pixel_y;
  logic        out_last_pixel;

  char_word_t char_q[$];
  pixel_t     pixel_q[$];
  char_word_t next_char;
  pixel_t     want_px;

  int send_idle_pct = 9;
  int recv_idle_pct = 63;
  int quiet_cycles = 0;
  int mismatches = 0;
  int chars_taken = 0;
  int chars_off_screen = 0;
  int pixels_checked = 0;

  glyph_cell_rasterizer_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_fore_colour (in_fore_colour),
    .in_back_colour (in_back_colour),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_word (out_pixel_word),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  always #2 clk = ~clk;

  // Five glyph columns, column 0 in the top byte; bit n of a column is row n.
  function automatic logic [39:0] font_columns(input int unsigned idx);
    logic [39:0] f;
    case (idx)
      0: f = 40'h0000000000;  1: f = 40'h00005F0000;  2: f = 40'h0007000700;
      3: f = 40'h147F147F14;  4: f = 40'h242A7F2A12;  5: f = 40'h2313086462;
      6: f = 40'h3649552250;  7: f = 40'h0005030000;  8: f = 40'h001C224100;
      9: f = 40'h0041221C00; 10: f = 40'h082A1C2A08; 11: f = 40'h08083E0808;
      12: f = 40'h0050300000; 13: f = 40'h0808080808; 14: f = 40'h0060600000;
      15: f = 40'h2010080402; 16: f = 40'h3E5149453E; 17: f = 40'h00427F4000;
      18: f = 40'h4261514946; 19: f = 40'h2141454B31; 20: f = 40'h1814127F10;
      21: f = 40'h2745454539; 22: f = 40'h3C4A494930; 23: f = 40'h0171090503;
      24: f = 40'h3649494936; 25: f = 40'h064949291E; 26: f = 40'h0036360000;
      27: f = 40'h0056360000; 28: f = 40'h0008142241; 29: f = 40'h1414141414;
      30: f = 40'h4122140800; 31: f = 40'h0201510906; 32: f = 40'h324979413E;
      33: f = 40'h7E1111117E; 34: f = 40'h7F49494936; 35: f = 40'h3E41414122;
      36: f = 40'h7F4141221C; 37: f = 40'h7F49494941; 38: f = 40'h7F09090901;
      39: f = 40'h3E4149497A; 40: f = 40'h7F0808087F; 41: f = 40'h00417F4100;
      42: f = 40'h2040413F01; 43: f = 40'h7F08142241; 44: f = 40'h7F40404040;
      45: f = 40'h7F020C027F; 46: f = 40'h7F0408107F; 47: f = 40'h3E4141413E;
      48: f = 40'h7F09090906; 49: f = 40'h3E4151215E; 50: f = 40'h7F09192946;
      51: f = 40'h4649494931; 52: f = 40'h01017F0101; 53: f = 40'h3F4040403F;
      54: f = 40'h1F2040201F; 55: f = 40'h3F4038403F; 56: f = 40'h6314081463;
      57: f = 40'h0708700807; 58: f = 40'h6151494543; 59: f = 40'h007F414100;
      60: f = 40'h0204081020; 61: f = 40'h0041417F00; 62: f = 40'h0402010204;
      63: f = 40'h4040404040; 64: f = 40'h0001020400; 65: f = 40'h2054545478;
      66: f = 40'h7F48444438; 67: f = 40'h3844444420; 68: f = 40'h384444487F;
      69: f = 40'h3854545418; 70: f = 40'h087E090102; 71: f = 40'h0C5252523E;
      72: f = 40'h7F08040478; 73: f = 40'h00447D4000; 74: f = 40'h2040443D00;
      75: f = 40'h7F10284400; 76: f = 40'h00417F4000; 77: f = 40'h7C04180478;
      78: f = 40'h7C08040478; 79: f = 40'h3844444438; 80: f = 40'h7C14141408;
      81: f = 40'h081414187C; 82: f = 40'h7C08040408; 83: f = 40'h4854545420;
      84: f = 40'h043F444020; 85: f = 40'h3C4040207C; 86: f = 40'h1C2040201C;
      87: f = 40'h3C4030403C; 88: f = 40'h4428102844; 89: f = 40'h0C5050503C;
      90: f = 40'h4464544C44; 91: f = 40'h0008364100; 92: f = 40'h00007F0000;
      93: f = 40'h0041360800; 94: f = 40'h1008081008;
      default: f = 40'h0;
    endcase
    return f;
  endfunction

  // Renders one character word into the pixel words it should produce: 48 for an on-screen origin, none otherwise.
  task automatic rasterize_cell(input char_word_t c);
    logic [7:0]  code;
    logic [39:0] cols;
    logic [7:0]  col_bits;
    logic [15:0] fg_wire;
    logic [15:0] bg_wire;
    logic        lit;
    pixel_t      px;
    int          row;
    int          col;
    if (c.x >= gcr_pkg::DISPLAY_WIDTH || c.y >= gcr_pkg::DISPLAY_HEIGHT) begin
      chars_off_screen++;
      return;
    end
    code = (c.code < gcr_pkg::FIRST_CODE || c.code > gcr_pkg::LAST_CODE)
           ? gcr_pkg::FALLBACK_CODE : c.code;
    cols = font_columns(int'(code - gcr_pkg::FIRST_CODE));
    fg_wire = {c.fg[7:0], c.fg[15:8]};
    bg_wire = {c.bg[7:0], c.bg[15:8]};
    for (row = 0; row < 8; row++) begin
      for (col = 0; col < 6; col++) begin
        lit = 1'b0;
        if (row < 7 && col < 5) begin
          col_bits = cols[39 - 8 * col -: 8];
          lit = col_bits[row];
        end
        px.colour = lit ? fg_wire : bg_wire;
        px.x = 11'(c.x) + 11'(col);
        px.y = 11'(c.y) + 11'(row);
        px.last = (row * 6 + col == CELL_PIXELS - 1);
        pixel_q.push_back(px);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_char(input logic [7:0] code, input logic [9:0] x,
                            input logic [9:0] y, input logic [15:0] fg,
                            input logic [15:0] bg);
    char_word_t c;
    c.code = code;
    c.x = x;
    c.y = y;
    c.fg = fg;
    c.bg = bg;
    char_q.push_back(c);
  endtask

  // Mostly printable characters placed on screen; the rest is noise across the
  // full field ranges, which also lands origins off screen.
  task automatic queue_random(input int on_screen);
    char_word_t c;
    int         placed;
    placed = 0;
    while (placed < on_screen) begin
      c.code = ($urandom_range(9, 0) < 7)
               ? 8'($urandom_range(gcr_pkg::LAST_CODE, gcr_pkg::FIRST_CODE))
               : 8'($urandom);
      case ($urandom_range(9, 0))
        0, 1: begin
          c.x = 10'($urandom);
          c.y = 10'($urandom);
        end
        2: begin
          c.x = 10'($urandom_range(gcr_pkg::DISPLAY_WIDTH - 1,
                                   gcr_pkg::DISPLAY_WIDTH - 6));
          c.y = 10'($urandom_range(gcr_pkg::DISPLAY_HEIGHT - 1,
                                   gcr_pkg::DISPLAY_HEIGHT - 8));
        end
        default: begin
          c.x = 10'($urandom_range(gcr_pkg::DISPLAY_WIDTH - 1, 0));
          c.y = 10'($urandom_range(gcr_pkg::DISPLAY_HEIGHT - 1, 0));
        end
      endcase
      c.fg = 16'($urandom);
      c.bg = 16'($urandom);
      if (c.x < gcr_pkg::DISPLAY_WIDTH && c.y < gcr_pkg::DISPLAY_HEIGHT) placed++;
      char_q.push_back(c);
    end
  endtask

  // Holds the sender back until every queued word is taken and every pixel seen.
  task automatic drain_all;
    while (char_q.size() != 0 || in_valid || pixel_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (char_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_char = char_q.pop_front();
        in_valid <= 1'b1;
        in_char_code <= next_char.code;
        in_cell_x <= next_char.x;
        in_cell_y <= next_char.y;
        in_fore_colour <= next_char.fg;
        in_back_colour <= next_char.bg;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Pixels are checked before the word taken on the same edge is rendered.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel word, expected none, actual %h at (%0d,%0d)",
                   $time, out_pixel_word, out_pixel_x, out_pixel_y);
          mismatches++;
        end else begin
          want_px = pixel_q.pop_front();
          check_field("pixel_word", want_px.colour, out_pixel_word);
          check_field("pixel_x", 16'(want_px.x), 16'(out_pixel_x));
          check_field("pixel_y", 16'(want_px.y), 16'(out_pixel_y));
          check_field("last_pixel", 16'(want_px.last), 16'(out_last_pixel));
        end
        pixels_checked++;
      end
      if (in_valid && !in_stall) begin
        rasterize_cell('{in_char_code, in_cell_x, in_cell_y, in_fore_colour,
                         in_back_colour});
        chars_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Printable range ends, codes just outside it and the high codes.
    queue_char(8'h20, 10'd0, 10'd0, 16'hFFFF, 16'h0000);
    queue_char(8'h7E, 10'd6, 10'd0, 16'h0000, 16'hFFFF);
    queue_char(8'h1F, 10'd12, 10'd8, 16'hF800, 16'h07E0);
    queue_char(8'h7F, 10'd18, 10'd8, 16'h001F, 16'hFFE0);
    queue_char(8'h00, 10'd24, 10'd16, 16'hFFFF, 16'h0000);
    queue_char(8'hFF, 10'd30, 10'd16, 16'h0000, 16'hFFFF);
    queue_char(8'h80, 10'd233, 10'd311, 16'h8001, 16'h7FFE);
    queue_char(8'h3F, 10'd36, 10'd24, 16'h1234, 16'hABCD);
    // Cells that fit exactly, and cells that run past the right and bottom edges.
    queue_char(8'h41, 10'd234, 10'd312, 16'h1234, 16'hABCD);
    queue_char(8'h40, 10'd239, 10'd319, 16'hFF00, 16'h00FF);
    queue_char(8'h57, 10'd239, 10'd0, 16'h5555, 16'hAAAA);
    queue_char(8'h67, 10'd0, 10'd319, 16'hAAAA, 16'h5555);
    // Origins at or past the display size give no pixels; three on-screen cells follow.
    queue_char(8'h41, 10'd240, 10'd0, 16'hFFFF, 16'h0000);
    queue_char(8'h41, 10'd0, 10'd320, 16'hFFFF, 16'h0000);
    queue_char(8'hAA, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF);
    queue_char(8'h23, 10'd100, 10'd100, 16'h5555, 16'hAAAA);
    queue_char(8'h4D, 10'd200, 10'd300, 16'hFFFF, 16'h0000);
    queue_char(8'h78, 10'd128, 10'd256, 16'h8001, 16'h8001);
    queue_random(24);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    drain_all();

    @(negedge clk);
    send_idle_pct = 63;
    recv_idle_pct = 9;
    queue_random(24);
    drain_all();

    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(24);
    drain_all();

    // Let any cell still inside the block show itself as an extra pixel.
    repeat (20) @(negedge clk);
    $display("Rendered %0d character cells (%0d with the origin off screen) and",
             chars_taken, chars_off_screen);
    $display("checked %0d pixel words under three sender and receiver gap patterns.",
             pixels_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
